/* hdl/ffc_pkg.sv */
`default_nettype none
package ffc_pkg;
  localparam logic [2:0] MODE_WIDEN  = 3'd0;
  localparam logic [2:0] MODE_NARROW = 3'd1;
  localparam logic [2:0] MODE_I2F    = 3'd2;
  localparam logic [2:0] MODE_F2I_RN = 3'd3;
  localparam logic [2:0] MODE_F2I_RZ = 3'd4;
  localparam logic [31:0] INDEF_I32 = 32'h8000_0000;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [31:0] word3;
  } in_req_t;

  typedef struct packed {
    logic [31:0] res0;
    logic [31:0] res1;
    logic [31:0] res2;
    logic [31:0] res3;
  } out_req_t;

  // Index of the highest set bit of a 32-bit word (0 when the word is zero).
  function automatic logic [4:0] lead32(input logic [31:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 5'(i);
    end
    return n;
  endfunction
endpackage
`default_nettype wire

/* hdl/ffc_if.sv */
`default_nettype none
interface ffc_in_if;
  logic             valid;
  logic             ready;
  ffc_pkg::in_req_t req;
  modport source (output valid, output req, input ready);
  modport sink   (input valid, input req, output ready);
endinterface

interface ffc_out_if;
  logic              valid;
  logic              ready;
  ffc_pkg::out_req_t req;
  modport source (output valid, output req, input ready);
  modport sink   (input valid, input req, output ready);
endinterface
`default_nettype wire

/* hdl/ffc_lane.sv */
`default_nettype none
// One 32-bit lane: integer to float and float to integer conversions.
module ffc_lane (
  input  wire logic [31:0] word,
  input  wire logic        nearest,
  output logic [31:0]      i2f,
  output logic [31:0]      f2i
);
  logic [31:0] mag, rm, sig, fm, q, rem, half;
  logic [4:0]  lead, sh;
  logic [24:0] r;
  logic [7:0]  ex, bexp;
  logic        up, neg;
  logic [8:0]  e;

  // Integer to float.
  always_comb begin
    mag  = word[31] ? (32'd0 - word) : word;
    lead = ffc_pkg::lead32(mag);
    rm   = mag << (5'd31 - lead);
    r    = {1'b0, rm[31:8]};
    up   = rm[7] && (rm[6:0] != 7'd0 || rm[8]);
    if (lead > 5'd23 && up) r = r + 25'd1;
    bexp = 8'(lead) + 8'd127;
    if (r[24]) bexp = bexp + 8'd1;
    i2f = (mag == 32'd0) ? 32'd0 : {word[31], bexp, r[22:0]};
  end

  // Float to integer.
  always_comb begin
    neg = word[31];
    ex  = word[30:23];
    sig = {8'd0, ex != 8'd0, word[22:0]};
    e   = (ex == 8'd0) ? 9'd1 : {1'b0, ex};
    fm  = 32'd0;
    q = 32'd0; rem = 32'd0; half = 32'd0; sh = 5'd0;
    if (e >= 9'd150) begin
      fm = sig << 5'(e - 9'd150);
    end else if (e >= 9'd126) begin
      sh   = 5'(9'd150 - e);
      q    = sig >> sh;
      rem  = sig & ((32'd1 << sh) - 32'd1);
      half = 32'd1 << (sh - 5'd1);
      fm   = q;
      if (nearest && (rem > half || (rem == half && q[0]))) fm = q + 32'd1;
    end
    if (ex == 8'hff || e >= 9'd158) f2i = ffc_pkg::INDEF_I32;
    else f2i = neg ? (32'd0 - fm) : fm;
  end
endmodule
`default_nettype wire

/* hdl/ffc_dbl.sv */
`default_nettype none
// Double-width lane: f32 to f64 and f64 to f32.
module ffc_dbl (
  input  wire logic [31:0] f,
  input  wire logic [63:0] d,
  output logic [63:0]      wide,
  output logic [31:0]      narrow
);
  logic [4:0]  lead;
  logic [22:0] fn;
  logic [10:0] dex;
  logic [52:0] sig;
  logic [23:0] r;
  logic [28:0] tail;
  logic        up;
  logic [7:0]  nexp;
  logic [5:0]  dsh;
  logic [52:0] sh53, lost;
  logic [23:0] dr;
  logic        dup;

  // Widen.
  always_comb begin
    lead = ffc_pkg::lead32({9'd0, f[22:0]});
    fn   = 23'(f[22:0] << (5'd23 - lead));
    if (f[30:23] == 8'hff)
      wide = {f[31], 11'h7ff, 1'b1, f[21:0], 29'd0};
    else if (f[30:23] != 8'd0)
      wide = {f[31], (f[30] ? 4'b1000 : 4'b0111), f[29:23], f[22:0], 29'd0};
    else if (f[22:0] == 23'd0)
      wide = {f[31], 63'd0};
    else
      wide = {f[31], 11'(11'd874 + 11'(lead)), fn, 29'd0};
    if (f[30:23] == 8'hff && f[22:0] == 23'd0) wide = {f[31], 11'h7ff, 52'd0};
  end

  // Narrow.
  always_comb begin
    dex  = d[62:52];
    sig  = {1'b1, d[51:0]};
    tail = sig[28:0];
    up   = tail[28] && (tail[27:0] != 28'd0 || sig[29]);
    r    = sig[52:29] + 24'(up);
    nexp = 8'(dex - 11'd896);
    dsh  = (dex >= 11'd873) ? 6'(11'd926 - dex) : 6'd63;
    sh53 = sig >> dsh;
    lost = sig & ((53'd1 << dsh) - 53'd1);
    dr   = sh53[23:0];
    dup  = lost > (53'd1 << (dsh - 6'd1)) ||
           (lost == (53'd1 << (dsh - 6'd1)) && dr[0]);
    dr   = dr + 24'(dup);
    if (dex == 11'h7ff)
      narrow = (d[51:0] == 52'd0) ? {d[63], 8'hff, 23'd0}
                                  : {d[63], 8'hff, 1'b1, d[50:29]};
    else if (dex == 11'd0)
      narrow = {d[63], 31'd0};
    else if (dex > 11'd1150)
      narrow = {d[63], 8'hff, 23'd0};
    else if (dex >= 11'd897) begin
      if (r == 24'd0)
        narrow = (dex == 11'd1150) ? {d[63], 8'hff, 23'd0}
                                   : {d[63], 8'(nexp + 8'd1), 23'd0};
      else
        narrow = {d[63], nexp, r[22:0]};
    end else if (dex < 11'd873)
      narrow = {d[63], 31'd0};
    else
      narrow = dr[23] ? {d[63], 8'd1, 23'd0} : {d[63], 8'd0, dr[22:0]};
  end
endmodule
`default_nettype wire

/* hdl/float_format_converter_x4.sv */
`default_nettype none
// Channel | Dir | Payload
// in_     | in  | mode, word0..word3
// out_    | out | res0..res3
// One request per cycle while the output is taken; the result appears in the cycle after acceptance.
// Latency is set by the single output register behind the four integer lanes and two double lanes.
// Synchronous active-low reset clears the output valid.
// The input is ready whenever the output register is empty or being taken.
module float_format_converter_x4 (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ffc_in_if.sink     in_ch,
  ffc_out_if.source  out_ch
);
  logic [31:0] w [4];
  logic [31:0] i2f [4];
  logic [31:0] f2i [4];
  logic [63:0] wide [2];
  logic [31:0] narrow [2];
  logic        nearest;
  ffc_pkg::out_req_t res_nxt, res_r;
  logic        vld_r;

  assign w[0] = in_ch.req.word0;
  assign w[1] = in_ch.req.word1;
  assign w[2] = in_ch.req.word2;
  assign w[3] = in_ch.req.word3;
  assign nearest = (in_ch.req.mode == ffc_pkg::MODE_F2I_RN);

  // Four integer lanes and two double lanes.
  for (genvar g = 0; g < 4; g++) begin : g_lane
    ffc_lane u_lane (.word(w[g]), .nearest(nearest), .i2f(i2f[g]), .f2i(f2i[g]));
  end
  for (genvar g = 0; g < 2; g++) begin : g_dbl
    ffc_dbl u_dbl (.f(w[g]), .d({w[2*g+1], w[2*g]}), .wide(wide[g]),
                   .narrow(narrow[g]));
  end

  // Merge lane results by mode.
  always_comb begin
    res_nxt = '0;
    unique case (in_ch.req.mode) inside
      ffc_pkg::MODE_WIDEN:
        res_nxt = {wide[0][31:0], wide[0][63:32], wide[1][31:0], wide[1][63:32]};
      ffc_pkg::MODE_NARROW:
        res_nxt = {narrow[0], narrow[1], 64'd0};
      ffc_pkg::MODE_I2F:
        res_nxt = {i2f[0], i2f[1], i2f[2], i2f[3]};
      ffc_pkg::MODE_F2I_RN, ffc_pkg::MODE_F2I_RZ:
        res_nxt = {f2i[0], f2i[1], f2i[2], f2i[3]};
      default: res_nxt = '0;
    endcase
  end

  assign in_ch.ready  = !vld_r || out_ch.ready;
  assign out_ch.valid = vld_r;
  assign out_ch.req   = res_r;

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      vld_r <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      res_r <= res_nxt;
    end
  end
endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb;
  logic clk;
  logic rst_n;

  ffc_in_if  in_ch ();
  ffc_out_if out_ch ();

  float_format_converter_x4 u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // Bit-exact conversion predictor for one request.
  function automatic logic [63:0] round_even_shr(input logic [63:0] v, input int unsigned sh);
    logic [63:0] q, rem, half;
    if (sh == 0) return v;
    if (sh >= 64) return 64'd0;
    q = v >> sh;
    rem = v - (q << sh);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 1;
    return q;
  endfunction

  function automatic int unsigned msb_index(input logic [63:0] v);
    int unsigned n;
    n = 0;
    for (int i = 0; i < 64; i++) if (v[i]) n = i;
    return n;
  endfunction

  function automatic logic [63:0] widen_lane(input logic [31:0] b);
    logic [63:0] s;
    logic [7:0] ex;
    logic [22:0] fr;
    int unsigned ld;
    s = {b[31], 63'd0};
    ex = b[30:23];
    fr = b[22:0];
    if (ex == 8'hff) begin
      if (fr == 0) return s | 64'h7ff0_0000_0000_0000;
      return s | 64'h7ff0_0000_0000_0000 | (64'(fr) << 29) | (64'd1 << 51);
    end
    if (ex != 0) return s | (64'(ex + 11'd896) << 52) | (64'(fr) << 29);
    if (fr == 0) return s;
    ld = msb_index(64'(fr));
    return s | (64'(ld + 874) << 52) | ((64'(fr) - (64'd1 << ld)) << (52 - ld));
  endfunction

  function automatic logic [31:0] narrow_lane(input logic [63:0] b);
    logic [31:0] s;
    logic [10:0] ex;
    logic [63:0] sig, r;
    int ub;
    s = {b[63], 31'd0};
    ex = b[62:52];
    if (ex == 11'h7ff) begin
      if (b[51:0] == 0) return s | 32'h7f80_0000;
      return s | 32'h7f80_0000 | 32'(b[51:29]) | 32'h0040_0000;
    end
    if (ex == 0) return s;
    ub = int'(ex) - 1023;
    sig = {11'd0, 1'b1, b[51:0]};
    if (ub > 127) return s | 32'h7f80_0000;
    if (ub >= -126) begin
      r = round_even_shr(sig, 29);
      if (r == (64'd1 << 24)) begin
        r = r >> 1;
        ub++;
        if (ub > 127) return s | 32'h7f80_0000;
      end
      return s | (32'(ub + 127) << 23) | (r[31:0] & 32'h007f_ffff);
    end
    r = round_even_shr(sig, -ub - 97);
    if (r >= (64'd1 << 23)) return s | 32'h0080_0000;
    return s | r[31:0];
  endfunction

  function automatic logic [31:0] int_to_float(input logic [31:0] v);
    logic [31:0] mag;
    logic [63:0] r;
    int unsigned ld;
    mag = v[31] ? -v : v;
    if (mag == 0) return 32'd0;
    ld = msb_index(64'(mag));
    if (ld <= 23) r = 64'(mag) << (23 - ld);
    else begin
      r = round_even_shr(64'(mag), ld - 23);
      if (r == (64'd1 << 24)) begin
        r = r >> 1;
        ld++;
      end
    end
    return (v & 32'h8000_0000) | (32'(ld + 127) << 23) | (r[31:0] & 32'h007f_ffff);
  endfunction

  function automatic logic [31:0] float_to_int(input logic [31:0] b, input bit nearest);
    logic [63:0] sig;
    logic [31:0] mag;
    int e;
    if (b[30:23] == 8'hff) return ffc_pkg::INDEF_I32;
    if (b[30:23] == 0) begin
      sig = 64'(b[22:0]);
      e = -126;
    end else begin
      sig = {40'd0, 1'b1, b[22:0]};
      e = int'(b[30:23]) - 127;
    end
    if (e >= 31) return ffc_pkg::INDEF_I32;
    if (e >= 23) mag = 32'(sig << (e - 23));
    else if (nearest) mag = 32'(round_even_shr(sig, 23 - e));
    else mag = (23 - e) >= 64 ? 32'd0 : 32'(sig >> (23 - e));
    return b[31] ? -mag : mag;
  endfunction

  function automatic ffc_pkg::out_req_t convert(input ffc_pkg::in_req_t q);
    ffc_pkg::out_req_t o;
    logic [63:0] d;
    o = '0;
    case (q.mode) inside
      ffc_pkg::MODE_WIDEN: begin
        d = widen_lane(q.word0);
        o.res0 = d[31:0];
        o.res1 = d[63:32];
        d = widen_lane(q.word1);
        o.res2 = d[31:0];
        o.res3 = d[63:32];
      end
      ffc_pkg::MODE_NARROW: begin
        o.res0 = narrow_lane({q.word1, q.word0});
        o.res1 = narrow_lane({q.word3, q.word2});
      end
      ffc_pkg::MODE_I2F: begin
        o.res0 = int_to_float(q.word0);
        o.res1 = int_to_float(q.word1);
        o.res2 = int_to_float(q.word2);
        o.res3 = int_to_float(q.word3);
      end
      ffc_pkg::MODE_F2I_RN, ffc_pkg::MODE_F2I_RZ: begin
        o.res0 = float_to_int(q.word0, q.mode == ffc_pkg::MODE_F2I_RN);
        o.res1 = float_to_int(q.word1, q.mode == ffc_pkg::MODE_F2I_RN);
        o.res2 = float_to_int(q.word2, q.mode == ffc_pkg::MODE_F2I_RN);
        o.res3 = float_to_int(q.word3, q.mode == ffc_pkg::MODE_F2I_RN);
      end
      default: o = '0;
    endcase
    return o;
  endfunction

  // Scoreboard holding the pending converted vectors.
  class conv_scoreboard;
    ffc_pkg::out_req_t pending[$];
    int errors;

    function void note_request(input ffc_pkg::in_req_t q);
      pending.push_back(convert(q));
    endfunction

    function void check_result(input ffc_pkg::out_req_t got);
      ffc_pkg::out_req_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (want.res0 !== got.res0 || want.res1 !== got.res1 ||
          want.res2 !== got.res2 || want.res3 !== got.res3) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %h actual %h", want, got);
      end
    endfunction
  endclass

  conv_scoreboard sb;
  int idle_pct;
  int stall_pct;
  bit hold_off;
  int unsigned cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Monitor both channels at each edge.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_request(in_ch.req);
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.req);
  end

  // Receiver stall generator.
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Offer one request; valid stays up until the next request or an idle cycle.
  task automatic send(input ffc_pkg::in_req_t q);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req <= q;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_f32();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(5))
      0: w[30:23] = 8'hff;
      1: w[30:23] = 8'h00;
      2: w[30:23] = 8'd127 + 8'($urandom_range(31));
      3: w[30:23] = 8'd126 + 8'($urandom_range(1));
      default: ;
    endcase
    if ($urandom_range(4) == 0) w[21:0] = $urandom_range(1) ? 22'h200000 : 22'h0;
    return w;
  endfunction

  function automatic logic [63:0] rand_f64();
    logic [63:0] d;
    d = {$urandom, $urandom};
    case ($urandom_range(5))
      0: d[62:52] = 11'h7ff;
      1: d[62:52] = 11'h0;
      2: d[62:52] = 11'd1023 - 11'd126 - 11'($urandom_range(26));
      3: d[62:52] = 11'd1023 + 11'd124 + 11'($urandom_range(6));
      default: ;
    endcase
    if ($urandom_range(3) == 0) d[28:0] = $urandom_range(1) ? 29'h1000_0000 : 29'h0;
    if ($urandom_range(5) == 0) d[51:29] = 23'h7f_ffff;
    return d;
  endfunction

  function automatic ffc_pkg::in_req_t rand_req();
    ffc_pkg::in_req_t q;
    logic [63:0] a, b;
    q.mode = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
    if (q.mode == ffc_pkg::MODE_NARROW) begin
      a = rand_f64();
      b = rand_f64();
      {q.word1, q.word0} = a;
      {q.word3, q.word2} = b;
    end else if (q.mode == ffc_pkg::MODE_I2F || $urandom_range(9) == 0) begin
      q.word0 = $urandom;
      q.word1 = $urandom >> $urandom_range(31);
      q.word2 = $urandom;
      q.word3 = -($urandom >> $urandom_range(31));
    end else begin
      q.word0 = rand_f32();
      q.word1 = rand_f32();
      q.word2 = rand_f32();
      q.word3 = rand_f32();
    end
    return q;
  endfunction

  // Stop offering and wait until every expected result has arrived.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    sb = new();
    idle_pct = 0;
    stall_pct = 0;
    hold_off = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corner cases for every mode.
    send({ffc_pkg::MODE_WIDEN, 32'h7fc0_0001, 32'hff80_0000, 32'h0, 32'h0});
    send({ffc_pkg::MODE_WIDEN, 32'h8000_0001, 32'h007f_ffff, 32'hffff_ffff, 32'h0});
    send({ffc_pkg::MODE_WIDEN, 32'h8000_0000, 32'h7f7f_ffff, 32'h0, 32'h0});
    send({ffc_pkg::MODE_NARROW, 32'h0000_0001, 32'hfff0_0000, 32'h0, 32'h7ff0_0000});
    send({ffc_pkg::MODE_NARROW, 32'hffff_ffff, 32'h47ef_ffff, 32'h1000_0000,
          32'h3ff0_0000});
    send({ffc_pkg::MODE_NARROW, 32'hffff_ffff, 32'h380f_ffff, 32'h0000_0001,
          32'h800f_ffff});
    send({ffc_pkg::MODE_NARROW, 32'h3000_0000, 32'h3690_0000, 32'h0, 32'h47f0_0000});
    send({ffc_pkg::MODE_NARROW, 32'h0, 32'h7ff8_0000, 32'hffff_ffff, 32'hffff_ffff});
    send({ffc_pkg::MODE_I2F, 32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff});
    send({ffc_pkg::MODE_I2F, 32'h0100_0001, 32'h0100_0003, 32'h1, 32'h00ff_ffff});
    send({ffc_pkg::MODE_F2I_RN, 32'h3f00_0000, 32'h3fc0_0000, 32'h4020_0000,
          32'hbf00_0000});
    send({ffc_pkg::MODE_F2I_RN, 32'h4f00_0000, 32'hcf00_0000, 32'h7fc0_0000,
          32'hff80_0000});
    send({ffc_pkg::MODE_F2I_RN, 32'h4eff_ffff, 32'h0000_0001, 32'h8000_0000,
          32'hcf00_0001});
    send({ffc_pkg::MODE_F2I_RZ, 32'h3fff_ffff, 32'hbfff_ffff, 32'h4f00_0000,
          32'hcf00_0000});
    send({ffc_pkg::MODE_F2I_RZ, 32'h7f80_0000, 32'h7f80_0001, 32'h4eff_ffff, 32'h0});
    send({3'd5, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
    send({3'd7, 32'h1234_5678, 32'h0, 32'h0, 32'h0});

    // Random phases with varying idle and stall rates.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 84; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 84; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      for (int i = 0; i < 150; i++) send(rand_req());
      // Sender pauses until every expected result has arrived.
      drain();
    end

    // Long receiver hold-off while requests keep coming.
    idle_pct = 0;
    stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (40) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 20; i++) send(rand_req());
    join

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
hdl/ffc_pkg.sv
hdl/ffc_if.sv
hdl/ffc_lane.sv
hdl/ffc_dbl.sv
hdl/float_format_converter_x4.sv
tb/tb.sv
